FILE: design/sb64_pkg.sv
// ----------------------------------------------------------------------------
// sb64_pkg: shared types and constants of the strict base64 decoder
// Character classes, the queue entry between front and back, and the result
// word carried on the output channel.
// ----------------------------------------------------------------------------
package sb64_pkg;

  localparam logic [7:0] CHR_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CHR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHR_SLASH = 8'h2F;  // '/'

  localparam logic [5:0] SEXTET_PLUS  = 6'd62;
  localparam logic [5:0] SEXTET_SLASH = 6'd63;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,  // no character in the word
    KIND_DATA = 2'd1,  // alphabet character
    KIND_PAD  = 2'd2,  // padding character
    KIND_BAD  = 2'd3   // anything else
  } chr_kind_e;

  typedef struct packed {
    logic [5:0] sextet;
    chr_kind_e  kind;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic [7:0] decoded_byte;
    logic       is_status;
    logic       rejected;
    logic       last_result;
  } result_t;

endpackage

FILE: design/sb64_in_if.sv
// ----------------------------------------------------------------------------
// sb64_in_if: text character channel
// One character word per handshake, with presence and end-of-text marks.
// ----------------------------------------------------------------------------
interface sb64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       has_char;
  logic       end_of_text;

  modport source (output valid, output text_char, output has_char,
                  output end_of_text, input ready);
  modport sink   (input valid, input text_char, input has_char,
                  input end_of_text, output ready);
endinterface

FILE: design/sb64_out_if.sv
// ----------------------------------------------------------------------------
// sb64_out_if: decoded result channel
// Carries decoded bytes and the final status word of each text.
// ----------------------------------------------------------------------------
interface sb64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] decoded_byte;
  logic       is_status;
  logic       rejected;
  logic       last_result;

  modport source (output valid, output decoded_byte, output is_status,
                  output rejected, output last_result, input ready);
  modport sink   (input valid, input decoded_byte, input is_status,
                  input rejected, input last_result, output ready);
endinterface

FILE: design/sb64_front.sv
// ----------------------------------------------------------------------------
// sb64_front: input acceptance and character classification
// Maps each incoming character to its class and 6-bit value and pushes the
// classified word into the queue whenever the queue has room.
// ----------------------------------------------------------------------------
module sb64_front (
  sb64_in_if.sink         text_i,
  input  logic            full_i,
  output logic            push_o,
  output sb64_pkg::entry_t entry_o
);

  logic [7:0] chr;

  assign chr          = text_i.text_char;
  assign text_i.ready = ~full_i;
  assign push_o       = text_i.valid & ~full_i;

  always_comb begin
    entry_o.last   = text_i.end_of_text;
    entry_o.sextet = '0;
    entry_o.kind   = sb64_pkg::KIND_NONE;
    if (text_i.has_char) begin
      entry_o.kind = sb64_pkg::KIND_DATA;
      if (chr inside {[8'h41:8'h5A]}) begin
        entry_o.sextet = 6'(chr - 8'h41);
      end else if (chr inside {[8'h61:8'h7A]}) begin
        entry_o.sextet = 6'(chr - 8'h61 + 8'd26);
      end else if (chr inside {[8'h30:8'h39]}) begin
        entry_o.sextet = 6'(chr - 8'h30 + 8'd52);
      end else if (chr == sb64_pkg::CHR_PLUS) begin
        entry_o.sextet = sb64_pkg::SEXTET_PLUS;
      end else if (chr == sb64_pkg::CHR_SLASH) begin
        entry_o.sextet = sb64_pkg::SEXTET_SLASH;
      end else if (chr == sb64_pkg::CHR_PAD) begin
        entry_o.kind = sb64_pkg::KIND_PAD;
      end else begin
        entry_o.kind = sb64_pkg::KIND_BAD;
      end
    end
  end

endmodule

FILE: design/sb64_queue.sv
// ----------------------------------------------------------------------------
// sb64_queue: short queue between front and back
// Register-based FIFO of classified words, so either side can stall alone.
// ----------------------------------------------------------------------------
module sb64_queue #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sb64_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output sb64_pkg::entry_t entry_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sb64_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

FILE: design/sb64_back.sv
// ----------------------------------------------------------------------------
// sb64_back: decode state and result generation
// Pops classified words, updates the sextet buffer and the padding and
// reject state, and drives the registered result channel. A word that ends
// a text and also yields a byte parks its status for one more output slot.
// ----------------------------------------------------------------------------
module sb64_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  sb64_pkg::entry_t head_i,
  output logic             pop_o,
  sb64_out_if.source       res_o
);

  localparam logic [1:0] GP_FIRST  = 2'd0;
  localparam logic [1:0] GP_SECOND = 2'd1;
  localparam logic [1:0] GP_THIRD  = 2'd2;
  localparam logic [1:0] GP_FOURTH = 2'd3;

  logic [5:0] buf_q, buf_d;
  logic [1:0] gp_q, gp_d;
  logic [1:0] pad_q, pad_d;
  logic       seen_q, seen_d;
  logic       rej_q, rej_d;

  logic                out_valid_q, out_valid_d;
  sb64_pkg::result_t   out_res_q, out_res_d;
  logic                pend_q, pend_d;
  logic                pend_rej_q, pend_rej_d;

  logic       can_load;
  logic       emit_byte;
  logic [7:0] byte_val;
  logic       bad;

  assign can_load = ~out_valid_q | res_o.ready;
  assign pop_o    = head_valid_i & ~pend_q & can_load;

  assign res_o.valid        = out_valid_q;
  assign res_o.decoded_byte = out_res_q.decoded_byte;
  assign res_o.is_status    = out_res_q.is_status;
  assign res_o.rejected     = out_res_q.rejected;
  assign res_o.last_result  = out_res_q.last_result;

  // next decode state for the head word
  always_comb begin
    buf_d     = buf_q;
    gp_d      = gp_q;
    pad_d     = pad_q;
    seen_d    = seen_q;
    rej_d     = rej_q;
    emit_byte = 1'b0;
    byte_val  = '0;
    case (head_i.kind)
      sb64_pkg::KIND_DATA: begin
        if (pad_q != 2'd0) begin
          rej_d = 1'b1;
        end else if (!rej_q) begin
          seen_d = 1'b1;
          gp_d   = gp_q + 1'b1;
          case (gp_q)
            GP_FIRST: begin
              buf_d = head_i.sextet;
            end
            GP_SECOND: begin
              emit_byte = 1'b1;
              byte_val  = {buf_q, head_i.sextet[5:4]};
              buf_d     = {2'b00, head_i.sextet[3:0]};
            end
            GP_THIRD: begin
              emit_byte = 1'b1;
              byte_val  = {buf_q[3:0], head_i.sextet[5:2]};
              buf_d     = {4'b0000, head_i.sextet[1:0]};
            end
            GP_FOURTH: begin
              emit_byte = 1'b1;
              byte_val  = {buf_q[1:0], head_i.sextet};
              buf_d     = '0;
            end
            default: begin
              buf_d = buf_q;
            end
          endcase
        end
      end
      sb64_pkg::KIND_PAD: begin
        if (pad_q >= 2'd2) begin
          pad_d = 2'd3;
          rej_d = 1'b1;
        end else begin
          pad_d = pad_q + 1'b1;
        end
      end
      sb64_pkg::KIND_BAD: begin
        rej_d = 1'b1;
      end
      default: begin
        rej_d = rej_q;
      end
    endcase
    bad = rej_d | (gp_d == GP_SECOND) | ((pad_d != 2'd0) & ~seen_d);
  end

  // output register and parked status
  always_comb begin
    out_valid_d = out_valid_q & ~res_o.ready;
    out_res_d   = out_res_q;
    pend_d      = pend_q;
    pend_rej_d  = pend_rej_q;
    if (pend_q && can_load) begin
      out_valid_d = 1'b1;
      out_res_d   = '{decoded_byte: '0, is_status: 1'b1,
                      rejected: pend_rej_q, last_result: 1'b1};
      pend_d      = 1'b0;
    end else if (pop_o) begin
      if (emit_byte) begin
        out_valid_d = 1'b1;
        out_res_d   = '{decoded_byte: byte_val, is_status: 1'b0,
                        rejected: 1'b0, last_result: 1'b0};
        pend_d      = head_i.last;
        pend_rej_d  = bad;
      end else if (head_i.last) begin
        out_valid_d = 1'b1;
        out_res_d   = '{decoded_byte: '0, is_status: 1'b1,
                        rejected: bad, last_result: 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= '0;
      gp_q        <= GP_FIRST;
      pad_q       <= '0;
      seen_q      <= 1'b0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
      if (pop_o) begin
        // end of text: clear for the next one
        if (head_i.last) begin
          buf_q  <= '0;
          gp_q   <= GP_FIRST;
          pad_q  <= '0;
          seen_q <= 1'b0;
          rej_q  <= 1'b0;
        end else begin
          buf_q  <= buf_d;
          gp_q   <= gp_d;
          pad_q  <= pad_d;
          seen_q <= seen_d;
          rej_q  <= rej_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    pend_rej_q <= pend_rej_d;
  end

`ifndef NO_ASSERTIONS
  a_pend_behind_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q)
    else $error("parked status without a byte ahead of it");

  a_status_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.is_status) |->
      (gp_q == GP_FIRST && pad_q == 2'd0 && !seen_q && !rej_q))
    else $error("decode state not cleared behind status");

  a_data_word_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.is_status) |->
      (!out_res_q.rejected && !out_res_q.last_result))
    else $error("data word carries status marks");

  a_no_pop_while_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !pop_o)
    else $error("word popped while a status is parked");
`endif

endmodule

FILE: design/strict_base64_decoder_unit.sv
// ----------------------------------------------------------------------------
// strict_base64_decoder_unit: strict base64 text decoder
// Usage:
//   text_i carries one character word per handshake (valid and ready high at
//   a rising edge), with has_char and end_of_text marks. result_o returns
//   decoded bytes as soon as they are known, from the second character of
//   each group of four on, and one status word on the last word of a text;
//   a rejected status tells the receiver to drop that text's bytes.
//   Throughput is one character per cycle while the receiver keeps ready high
//   and no status is parked; a word that yields both a byte and the status
//   puts the byte on the output first and the status word after it. An
//   accepted word passes the classification queue, then the output register.
//   The queue is QueueDepth words deep; text_i.ready drops only when it is
//   full, so a stalled receiver backs up the queue and then the sender.
//   Reset clears the queue, the output register and all decode state; the
//   decode state also returns to its reset values after each status word.
// ----------------------------------------------------------------------------
module strict_base64_decoder_unit #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sb64_in_if.sink     text_i,
  sb64_out_if.source  result_o
);

  logic             push;
  logic             full;
  sb64_pkg::entry_t push_entry;
  logic             head_valid;
  sb64_pkg::entry_t head_entry;
  logic             pop;

  sb64_front u_front (
    .text_i  (text_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  sb64_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .entry_o (head_entry)
  );

  sb64_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_entry),
    .pop_o        (pop),
    .res_o        (result_o)
  );

endmodule
